// ----- src/ced_pkg.sv -----
// ----------------------------------------------------------------------------
// ced_pkg
// Shared types, constants and helpers of the color edge detector.
// ----------------------------------------------------------------------------
package ced_pkg;

  localparam int MAX_WIDTH_DEFAULT = 1024;

  localparam int IMG_W   = 11;
  localparam int THR_W   = 18;
  localparam int CHAN_W  = 8;
  localparam int LEVEL_W = 8;
  localparam int DIST_W  = 18;
  localparam int CFG_W   = 18;

  localparam logic [0:0] REG_IMAGE_WIDTH = 1'd0;
  localparam logic [0:0] REG_THRESHOLD   = 1'd1;

  localparam logic [IMG_W-1:0] IMAGE_WIDTH_RESET = 11'd640;
  localparam logic [THR_W-1:0] THRESHOLD_RESET   = 18'd225;

  localparam logic [LEVEL_W-1:0] LEVEL_EDGE   = 8'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_SMOOTH = 8'd255;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } pixel_t;

  localparam int PIXEL_W = $bits(pixel_t);

  function automatic logic [2*CHAN_W-1:0] chan_sq(input logic [CHAN_W-1:0] x,
                                                  input logic [CHAN_W-1:0] y);
    logic [CHAN_W-1:0] d;
    d = (x > y) ? (x - y) : (y - x);
    return {{CHAN_W{1'b0}}, d} * {{CHAN_W{1'b0}}, d};
  endfunction

  function automatic logic [DIST_W-1:0] color_dist_sq(input pixel_t p, input pixel_t q);
    return DIST_W'(chan_sq(p.r, q.r)) + DIST_W'(chan_sq(p.g, q.g))
         + DIST_W'(chan_sq(p.b, q.b));
  endfunction

endpackage

// ----- src/ced_ram.sv -----
// ----------------------------------------------------------------------------
// ced_ram
// Generic single-write, single-read RAM with registered read (old data on
// a same-address write).
// ----------------------------------------------------------------------------
module ced_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/ced_ctrl.sv -----
// ----------------------------------------------------------------------------
// ced_ctrl
// Column and first-row tracking; gives the column and border flag of the
// pixel being accepted.
// ----------------------------------------------------------------------------
module ced_ctrl
  import ced_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [IMG_W-1:0]             image_width,
  input  logic                         frame_start,
  input  logic                         accept,
  output logic [$clog2(MAX_WIDTH)-1:0] col,
  output logic                         border
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CMPW = (CW + 1 > IMG_W) ? CW + 1 : IMG_W;

  logic [CW-1:0]   column_count;
  logic [CW-1:0]   column_count_next;
  logic            first_row;
  logic            first_row_next;
  logic [CMPW-1:0] img_ext;
  logic [CMPW-1:0] w_eff;
  logic [CW-1:0]   col_start;
  logic            fr_start;
  logic            wrap;
  logic            fr;
  logic [CMPW-1:0] col_inc;
  logic            end_row;

  always_comb begin
    img_ext = CMPW'(image_width);
    if (img_ext < CMPW'(2)) begin
      w_eff = CMPW'(2);
    end else if (img_ext > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = img_ext;
    end
    col_start = frame_start ? '0 : column_count;
    fr_start  = frame_start | first_row;
    wrap      = CMPW'(col_start) >= w_eff;
    col       = wrap ? '0 : col_start;
    fr        = wrap ? 1'b0 : fr_start;
    border    = fr | (col == '0);
    col_inc   = CMPW'(col) + CMPW'(1);
    end_row   = col_inc >= w_eff;
    column_count_next = end_row ? '0 : col_inc[CW-1:0];
    first_row_next    = end_row ? 1'b0 : fr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      first_row    <= 1'b1;
    end else if (accept) begin
      column_count <= column_count_next;
      first_row    <= first_row_next;
    end
  end

endmodule

// ----- src/ced_dist.sv -----
// ----------------------------------------------------------------------------
// ced_dist
// Squared color distances to the pixels above and to the left, threshold
// compare and the result register.
// ----------------------------------------------------------------------------
module ced_dist
  import ced_pkg::*;
(
  input  logic               clk,
  input  logic               load,
  input  pixel_t             pix,
  input  pixel_t             above,
  input  pixel_t             left,
  input  logic               border,
  input  logic [THR_W-1:0]   threshold_squared,
  output logic [LEVEL_W-1:0] level,
  output logic               on_border
);

  logic [DIST_W-1:0] dist_above;
  logic [DIST_W-1:0] dist_left;
  logic              edge_hit;

  always_comb begin
    dist_above = color_dist_sq(pix, above);
    dist_left  = color_dist_sq(pix, left);
    edge_hit   = (dist_above >= threshold_squared) | (dist_left >= threshold_squared);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      level     <= (border | edge_hit) ? LEVEL_EDGE : LEVEL_SMOOTH;
      on_border <= border;
    end
  end

endmodule

// ----- src/color_edge_detector_top.sv -----
// ----------------------------------------------------------------------------
// color_edge_detector_top
// RGB edge detector on a raster pixel stream with a one-row line buffer.
//
//   channel  direction  handshake             payload
//   input    in         in_valid / in_ready   red, green, blue, frame_start
//   output   out        out_valid / out_ready level, on_border
//   config   in         cfg_we                cfg_addr, cfg_wdata
//
// One pixel per clock sustained while the output is not stalled; a result
// passes the line buffer read stage, then the distance and result register.
// The line buffer has one write and one read port, both used at accept.
// Reset clears counters and valid flags; the line buffer is not cleared.
// A stalled output holds the pipeline; a new pixel is taken whenever the
// read stage is empty or moves on.
// ----------------------------------------------------------------------------
module color_edge_detector_top
  import ced_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_addr,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CHAN_W-1:0]  red,
  input  logic [CHAN_W-1:0]  green,
  input  logic [CHAN_W-1:0]  blue,
  input  logic               frame_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LEVEL_W-1:0] level,
  output logic               on_border
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [IMG_W-1:0] image_width;
  logic [THR_W-1:0] threshold_squared;
  logic             accept;
  logic             advance;
  logic             s1_valid;
  pixel_t           pix_in;
  pixel_t           s1_pix;
  pixel_t           s1_left;
  logic             s1_border;
  pixel_t           above;
  pixel_t           left_pixel;
  logic [CW-1:0]    col;
  logic             border;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width       <= IMAGE_WIDTH_RESET;
      threshold_squared <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_IMAGE_WIDTH: image_width       <= cfg_wdata[IMG_W-1:0];
        REG_THRESHOLD:   threshold_squared <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign pix_in   = '{r: red, g: green, b: blue};
  assign advance  = s1_valid & (~out_valid | out_ready);
  assign in_ready = ~s1_valid | advance;
  assign accept   = in_valid & in_ready;

  ced_ctrl #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .image_width(image_width),
    .frame_start(frame_start),
    .accept     (accept),
    .col        (col),
    .border     (border)
  );

  ced_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_buf (
    .clk  (clk),
    .we   (accept),
    .waddr(col),
    .wdata(pix_in),
    .re   (accept),
    .raddr(col),
    .rdata(above)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel <= '0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        left_pixel <= pix_in;
        s1_valid   <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix    <= pix_in;
      s1_left   <= left_pixel;
      s1_border <= border;
    end
  end

  ced_dist u_dist (
    .clk              (clk),
    .load             (advance),
    .pix              (s1_pix),
    .above            (above),
    .left             (s1_left),
    .border           (s1_border),
    .threshold_squared(threshold_squared),
    .level            (level),
    .on_border        (on_border)
  );

endmodule
